@@ src/vnos_pkg.sv @@
// Package for the value noise octave sampler: payload types, register map,
// and the cosine blend weight function. No dependencies.
package vnos_pkg;

    localparam int MAX_CELLS_D = 16;
    localparam int OUT_MAX_D = 1024;
    localparam int WEIGHT_TABLE_BITS_D = 8;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [3:0] ADDR_CELLS = 4'h0;
    localparam logic [3:0] ADDR_STEP_X = 4'h4;
    localparam logic [3:0] ADDR_STEP_Y = 4'h8;
    localparam logic [3:0] ADDR_WRAP = 4'hC;

    typedef struct packed {
        logic        command;
        logic [9:0]  row;
        logic [9:0]  col;
        logic [15:0] value;
    } t_in;

    typedef struct packed {
        logic        is_sample;
        logic [15:0] noise;
    } t_out;

    function automatic logic [15:0] blend_weight(input int unsigned idx, input int unsigned bits);
        logic [63:0] theta;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      w;
        begin
            theta = (64'd843314857 * 64'(idx)) >> bits;
            x2 = (theta * theta) >> 28;
            term = 64'd1 << 28;
            sum = longint'(1) << 28;
            for (int k = 1; k <= 14; k++) begin
                term = ((term * x2) >> 28) / 64'((2 * k - 1) * (2 * k));
                if ((k % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            w = (longint'(1) << 28) - sum;
            if (w < 0) begin
                w = 0;
            end
            if (w > (longint'(1) << 29)) begin
                w = longint'(1) << 29;
            end
            w = (w + 4096) >>> 13;
            if (w > 65535) begin
                w = 65535;
            end
            return 16'(w);
        end
    endfunction

endpackage

@@ src/vnos_regs.sv @@
// APB configuration registers of the value noise sampler.
// Depends on vnos_pkg.
module vnos_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [4:0]  o_cells,
    output logic [19:0] o_step_x,
    output logic [19:0] o_step_y,
    output logic        o_wrap
);
    import vnos_pkg::*;

    logic [4:0]  r_cells;
    logic [19:0] r_step_x;
    logic [19:0] r_step_y;
    logic        r_wrap;
    logic        wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells <= 5'd1;
            r_step_x <= '0;
            r_step_y <= '0;
            r_wrap <= 1'b0;
        end else if (wr) begin
            case (paddr)
                ADDR_CELLS:  r_cells <= pwdata[4:0];
                ADDR_STEP_X: r_step_x <= pwdata[19:0];
                ADDR_STEP_Y: r_step_y <= pwdata[19:0];
                ADDR_WRAP:   r_wrap <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_CELLS:  prdata = {27'd0, r_cells};
            ADDR_STEP_X: prdata = {12'd0, r_step_x};
            ADDR_STEP_Y: prdata = {12'd0, r_step_y};
            ADDR_WRAP:   prdata = {31'd0, r_wrap};
            default:     prdata = '0;
        endcase
    end

    assign o_cells = r_cells;
    assign o_step_x = r_step_x;
    assign o_step_y = r_step_y;
    assign o_wrap = r_wrap;
endmodule

@@ src/vnos_lattice.sv @@
// Lattice store: two copies of the lattice memory, each with two corner read ports,
// both written together. Reads are registered. Depends on vnos_pkg.
module vnos_lattice #(
    parameter int DEPTH = 289,
    parameter int AW = 9
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [15:0]       i_wdata,
    input  logic [4*AW-1:0]   i_raddr,
    output logic [63:0]       o_rdata
);
    import vnos_pkg::*;

    for (genvar g = 0; g < 2; g++) begin : g_bank
        logic [15:0] mem [DEPTH];
        logic [15:0] r_rd_a;
        logic [15:0] r_rd_b;
        always_ff @(posedge i_clk) begin
            if (i_we) begin
                mem[i_waddr] <= i_wdata;
            end
            r_rd_a <= mem[i_raddr[AW*(2*g) +: AW]];
            r_rd_b <= mem[i_raddr[AW*(2*g+1) +: AW]];
        end
        assign o_rdata[32*g +: 16] = r_rd_a;
        assign o_rdata[32*g+16 +: 16] = r_rd_b;
    end
endmodule

@@ src/value_noise_octave_sampler.sv @@
// Value noise octave sampler, top level. Depends on vnos_pkg, vnos_regs, vnos_lattice.
// Throughput is one beat per cycle; start is never refused (busy stays low).
// An accepted beat passes in turn through the address multiply, the lattice read, the
// x blend and the y blend registers before it drives its result beat.
// Reset clears the configuration and the pipeline; the lattice is undefined until loaded.
// Reads that meet a lattice write still in flight take its data by forwarding.
module value_noise_octave_sampler #(
    parameter int MAX_CELLS = vnos_pkg::MAX_CELLS_D,
    parameter int OUT_MAX = vnos_pkg::OUT_MAX_D,
    parameter int WEIGHT_TABLE_BITS = vnos_pkg::WEIGHT_TABLE_BITS_D
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  vnos_pkg::t_in  i_data,
    output logic           o_valid,
    output vnos_pkg::t_out o_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import vnos_pkg::*;

    localparam int LSIDE = MAX_CELLS + 1;
    localparam int DEPTH = LSIDE * LSIDE;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(LSIDE);
    localparam int WSIZE = 1 << WEIGHT_TABLE_BITS;

    logic [4:0]  cells;
    logic [19:0] step_x;
    logic [19:0] step_y;
    logic        wrap;

    vnos_regs u_regs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_cells(cells), .o_step_x(step_x),
        .o_step_y(step_y), .o_wrap(wrap)
    );

    logic [15:0] wtab [WSIZE];
    for (genvar g = 0; g < WSIZE; g++) begin : g_w
        assign wtab[g] = blend_weight(g, WEIGHT_TABLE_BITS);
    end

    assign busy = 1'b0;

    logic [CW:0] eff_cells;
    always_comb begin
        if (cells == 5'd0) begin
            eff_cells = (CW+1)'(1);
        end else if (32'(cells) > MAX_CELLS) begin
            eff_cells = (CW+1)'(MAX_CELLS);
        end else begin
            eff_cells = (CW+1)'(cells);
        end
    end

    // Stage 1: clamp and multiply.
    logic        acc;
    logic [9:0]  rc, cc;
    assign acc = start && !busy;
    always_comb begin
        rc = i_data.row;
        cc = i_data.col;
        if (32'(i_data.row) >= OUT_MAX) rc = 10'(OUT_MAX - 1);
        if (32'(i_data.col) >= OUT_MAX) cc = 10'(OUT_MAX - 1);
    end

    logic        r_s1_v, r_s1_cmd;
    logic [9:0]  r_s1_row, r_s1_col;
    logic [15:0] r_s1_val;
    logic [29:0] r_s1_px, r_s1_py;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= acc;
        end
        r_s1_cmd <= i_data.command;
        r_s1_row <= i_data.row;
        r_s1_col <= i_data.col;
        r_s1_val <= i_data.value;
        r_s1_px <= 30'(rc) * 30'(step_x);
        r_s1_py <= 30'(cc) * 30'(step_y);
    end

    // Stage 2 address generation.
    logic [13:0] xi, yi;
    logic [CW:0] x1, x2, y1, y2;
    logic        ld_ok, ld_wr, ld_fwd;
    logic [CW:0] lr, lc, sr, sc;
    logic [4*AW-1:0] raddr;
    logic [AW-1:0] ld_addr;
    logic [WEIGHT_TABLE_BITS-1:0] fx, fy;

    function automatic logic [AW-1:0] lidx(input logic [CW:0] r, input logic [CW:0] c);
        return AW'(32'(r) * LSIDE + 32'(c));
    endfunction

    always_comb begin
        xi = r_s1_px[29:16];
        yi = r_s1_py[29:16];
        x1 = (xi > 14'(eff_cells)) ? eff_cells : (CW+1)'(xi);
        y1 = (yi > 14'(eff_cells)) ? eff_cells : (CW+1)'(yi);
        x2 = (x1 == eff_cells) ? eff_cells : x1 + (CW+1)'(1);
        y2 = (y1 == eff_cells) ? eff_cells : y1 + (CW+1)'(1);
        fx = r_s1_px[15 -: WEIGHT_TABLE_BITS];
        fy = r_s1_py[15 -: WEIGHT_TABLE_BITS];
        lr = (CW+1)'(r_s1_row);
        lc = (CW+1)'(r_s1_col);
        ld_ok = (r_s1_row <= 10'(eff_cells)) && (r_s1_col <= 10'(eff_cells));
        ld_fwd = wrap && ((r_s1_row == 10'(eff_cells)) || (r_s1_col == 10'(eff_cells)));
        sr = (wrap && r_s1_row == 10'(eff_cells)) ? '0 : lr;
        sc = (wrap && r_s1_row == 10'(eff_cells)) ? lc : '0;
        ld_addr = lidx(lr, lc);
        ld_wr = r_s1_v && (r_s1_cmd == CMD_LOAD) && ld_ok;
        if (r_s1_cmd == CMD_SAMPLE) begin
            raddr = {lidx(x2, y2), lidx(x1, y2), lidx(x2, y1), lidx(x1, y1)};
        end else begin
            raddr = {4{lidx(sr, sc)}};
        end
    end

    // Stage 2 register; memory read happens in the same edge.
    logic        r_s2_v, r_s2_cmd, r_s2_wr, r_s2_fwd;
    logic [AW-1:0] r_s2_addr, r_s2_src, r_s2_a1, r_s2_a2, r_s2_a3;
    logic [15:0] r_s2_val, r_s2_wx, r_s2_wy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_s2_wr <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
            r_s2_wr <= ld_wr;
        end
        r_s2_cmd <= r_s1_cmd;
        r_s2_fwd <= ld_fwd;
        r_s2_addr <= ld_addr;
        r_s2_src <= raddr[AW-1:0];
        r_s2_a1 <= raddr[2*AW-1:AW];
        r_s2_a2 <= raddr[3*AW-1:2*AW];
        r_s2_a3 <= raddr[4*AW-1:3*AW];
        r_s2_val <= r_s1_val;
        r_s2_wx <= wtab[fx];
        r_s2_wy <= wtab[fy];
    end

    // Stage 3: read data available, resolve load value, write memory.
    // The write committed at the previous edge is forwarded into every corner.
    logic [63:0] rd;
    logic [15:0] wdata;
    logic        r_s3_wr;
    logic [AW-1:0] r_s3_addr;
    logic [15:0] r_s3_wdata;
    logic [15:0] s0, s1, s2, s3;
    always_comb begin
        s0 = (r_s3_wr && r_s3_addr == r_s2_src) ? r_s3_wdata : rd[15:0];
        s1 = (r_s3_wr && r_s3_addr == r_s2_a1) ? r_s3_wdata : rd[31:16];
        s2 = (r_s3_wr && r_s3_addr == r_s2_a2) ? r_s3_wdata : rd[47:32];
        s3 = (r_s3_wr && r_s3_addr == r_s2_a3) ? r_s3_wdata : rd[63:48];
        wdata = r_s2_fwd ? s0 : r_s2_val;
    end

    vnos_lattice #(.DEPTH(DEPTH), .AW(AW)) u_lat (
        .i_clk(i_clk), .i_we(r_s2_wr), .i_waddr(r_s2_addr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rd)
    );

    // Stage 3 also performs the first x blends.
    function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] w);
        logic [33:0] r;
        r = 34'(a) * (34'd65536 - 34'(w)) + 34'(b) * 34'(w) + 34'd32768;
        return r[31:16];
    endfunction

    logic        r_s3_v, r_s3_cmd;
    logic [15:0] r_s3_v1, r_s3_v2, r_s3_wy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
            r_s3_wr <= 1'b0;
        end else begin
            r_s3_v <= r_s2_v;
            r_s3_wr <= r_s2_wr;
        end
        r_s3_addr <= r_s2_addr;
        r_s3_wdata <= wdata;
        r_s3_cmd <= r_s2_cmd;
        r_s3_v1 <= blend(s0, s1, r_s2_wx);
        r_s3_v2 <= blend(s2, s3, r_s2_wx);
        r_s3_wy <= r_s2_wy;
    end

    logic r_s4_v;
    t_out r_s4_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else begin
            r_s4_v <= r_s3_v;
        end
        r_s4_out.is_sample <= r_s3_cmd;
        r_s4_out.noise <= (r_s3_cmd == CMD_SAMPLE) ? blend(r_s3_v1, r_s3_v2, r_s3_wy) : 16'd0;
    end

    assign o_valid = r_s4_v;
    assign o_data = r_s4_out;
endmodule
